// ===== design/revolution_scan_framer_macros.svh =====
// Assertion helpers for the scan framer checker.
`ifndef REVOLUTION_SCAN_FRAMER_MACROS_SVH
`define REVOLUTION_SCAN_FRAMER_MACROS_SVH

// Clocked check, masked while reset is held.
`define RSF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RSF_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/rsf_pkg.sv =====
package rsf_pkg;

    localparam int MaxFrameDef = 4096;
    localparam int CntW        = 12;
    localparam int CntMax      = (1 << CntW) - 1;
    localparam int SumW        = 20;
    localparam int TurnW       = 9;
    localparam int DistW       = 16;
    localparam int TickW       = 32;
    localparam int GapCfgW     = 16;
    localparam int TurnCfgW    = 8;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 16;
    localparam int KindW       = 2;

    localparam logic [CfgIdxW-1:0] REG_MARK_GAP_MIN  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_LONG_GAP_MIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SHORT_GAP_MAX = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WARMUP_TURNS  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MEASURE_TURNS = 3'd4;

    localparam logic [GapCfgW-1:0]  MARK_GAP_RST  = 16'd800;
    localparam logic [GapCfgW-1:0]  LONG_GAP_RST  = 16'd900;
    localparam logic [GapCfgW-1:0]  SHORT_GAP_RST = 16'd200;
    localparam logic [TurnCfgW-1:0] WARMUP_RST    = 8'd10;
    localparam logic [TurnCfgW-1:0] MEASURE_RST   = 8'd10;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_EDGE   = 1'b1;

    localparam logic [KindW-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KindW-1:0] KIND_END    = 2'd1;
    localparam logic [KindW-1:0] KIND_CAL    = 2'd2;

    // s_tdata layout, lowest bits last in the list
    typedef struct packed {
        logic [6:0]       fill;
        logic [TickW-1:0] edge_tick;
        logic             edge_level;
        logic [DistW-1:0] distance_cm;
    } in_data_t;

    // m_tdata layout
    typedef struct packed {
        logic [CntW-1:0]  dropped_count;
        logic [CntW-1:0]  pad_count;
        logic [CntW-1:0]  frame_length;
        logic [DistW-1:0] sample_value;
        logic [CntW-1:0]  sample_index;
    } out_data_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic move;
    } cmd_t;

    typedef struct packed {
        logic res_now;
        logic need_div;
        logic div_done;
    } sts_t;

endpackage

// ===== design/revolution_scan_framer.sv =====
// Frames a rotating range scanner's samples into turns. Range samples
// (s_tuser 0) and hall edges (s_tuser 1) that give no result are taken one
// beat per cycle while the result stage is empty and no division runs. A
// beat that gives a result holds the input until the result moves from the
// result stage into the output register, so result-bearing beats are not
// taken back to back. One further beat is taken while a result waits
// downstream. The hall edge that completes calibration holds the input
// while the 20-step shift-subtract divider averages the measured turns'
// sample counts into the frame length. Samples before calibration are
// counted silently; afterwards each turn passes samples below the frame
// length and ends with a frame-end beat giving pad and drop counts.
// Configuration writes are registered and are meant for idle periods.
module revolution_scan_framer
    import rsf_pkg::*;
#(
    parameter int MAX_FRAME = MaxFrameDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,   // opcode
    input  logic [55:0]         s_tdata,   // distance_cm, edge_level, edge_tick, zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [KindW-1:0]    m_tuser,   // result_kind
    output logic [63:0]         m_tdata,   // sample_index, sample_value, frame_length,
                                           // pad_count, dropped_count
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsf_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/rsf_div.sv =====
module rsf_div
    import rsf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SumW-1:0]  dividend,
    input  logic [TurnW-1:0] divisor,
    output logic             done,
    output logic [SumW-1:0]  quotient
);

    localparam int StepW = $clog2(SumW);
    localparam logic [StepW-1:0] LastStep = StepW'(SumW - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [SumW-1:0]  quot_reg, quot_next;
    logic [TurnW-1:0] rem_reg, rem_next;
    logic [TurnW-1:0] dvs_reg, dvs_next;
    logic [TurnW:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quot_reg[SumW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // one quotient bit per cycle, shifted in from the bottom
            quot_next = {quot_reg[SumW-2:0], fits};
            rem_next  = fits ? TurnW'(trial - {1'b0, dvs_reg}) : trial[TurnW-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LastStep) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== design/rsf_datapath.sv =====
module rsf_datapath
    import rsf_pkg::*;
#(
    parameter int MAX_FRAME = MaxFrameDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                s_tuser,
    input  logic [55:0]         s_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output logic [KindW-1:0]    m_tuser,
    output logic [63:0]         m_tdata
);

    localparam logic [CntW-1:0] SampleCap =
        (MAX_FRAME - 1 < CntMax) ? CntW'(MAX_FRAME - 1) : CntW'(CntMax);

    in_data_t in_d;
    assign in_d = in_data_t'(s_tdata);

    logic [GapCfgW-1:0]  mark_reg, long_reg, short_reg;
    logic [TurnCfgW-1:0] warm_reg, meas_reg;

    logic [TickW-1:0] fall_reg, fall_next;
    logic [TickW-1:0] prev_reg, prev_next;
    logic             armed_reg, armed_next;
    logic             cal_reg, cal_next;
    logic [TurnW-1:0] tc_reg, tc_next;
    logic [SumW-1:0]  sum_reg, sum_next;
    logic [CntW-1:0]  frame_reg, frame_next;
    logic [CntW-1:0]  ts_reg, ts_next;

    logic [KindW-1:0] res_kind_reg, res_kind_next;
    out_data_t        res_data_reg, res_data_next;
    logic [KindW-1:0] out_kind_reg, out_kind_next;
    out_data_t        out_data_reg, out_data_next;

    logic [TickW-1:0] gap;
    logic             is_rise, arm, close_turn, hit;
    logic [TurnW-1:0] warm9, meas9, tc_inc;
    logic [SumW:0]    sum_add;
    logic [SumW-1:0]  sum_sat;
    logic             div_done;
    logic [SumW-1:0]  quotient;
    logic [CntW-1:0]  q_sat;
    logic             sample_out;

    assign gap     = in_d.edge_tick - fall_reg;
    assign is_rise = (s_tuser == OP_EDGE) && in_d.edge_level;
    assign arm     = gap > TickW'(mark_reg);
    assign close_turn = is_rise && !arm && armed_reg && (prev_reg > TickW'(long_reg))
                        && (gap < TickW'(short_reg));

    assign warm9   = TurnW'(warm_reg);
    assign meas9   = (meas_reg == '0) ? TurnW'(1) : TurnW'(meas_reg);
    assign tc_inc  = tc_reg + 1'b1;
    assign hit     = tc_inc == TurnW'(warm9 + meas9);
    assign sum_add = {1'b0, sum_reg} + (SumW + 1)'(ts_reg);
    assign sum_sat = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
    assign q_sat   = (quotient > SumW'(SampleCap)) ? SampleCap : quotient[CntW-1:0];

    assign sample_out = (s_tuser == OP_SAMPLE) && cal_reg && (ts_reg < frame_reg);

    assign sts.res_now  = sample_out || (close_turn && cal_reg);
    assign sts.need_div = close_turn && !cal_reg && hit;
    assign sts.div_done = div_done;

    rsf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept && sts.need_div),
        .dividend (sum_sat),
        .divisor  (meas9),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        fall_next     = fall_reg;
        prev_next     = prev_reg;
        armed_next    = armed_reg;
        cal_next      = cal_reg;
        tc_next       = tc_reg;
        sum_next      = sum_reg;
        frame_next    = frame_reg;
        ts_next       = ts_reg;
        res_kind_next = res_kind_reg;
        res_data_next = res_data_reg;
        out_kind_next = out_kind_reg;
        out_data_next = out_data_reg;

        if (cmd.accept) begin
            if (s_tuser == OP_SAMPLE) begin
                if (ts_reg != SampleCap) begin
                    ts_next = ts_reg + 1'b1;
                end
                res_kind_next = KIND_SAMPLE;
                res_data_next = '{dropped_count: '0, pad_count: '0,
                                  frame_length: frame_reg,
                                  sample_value: in_d.distance_cm,
                                  sample_index: ts_reg};
            end else if (in_d.edge_level) begin
                prev_next = gap;
                if (arm) begin
                    armed_next = 1'b1;
                end else if (close_turn) begin
                    armed_next = 1'b0;
                    ts_next    = '0;
                    if (!cal_reg) begin
                        tc_next = hit ? TurnW'(tc_inc - warm9) : tc_inc;
                        if (hit) begin
                            cal_next = 1'b1;
                            sum_next = sum_sat;
                        end else if (tc_inc > warm9) begin
                            sum_next = sum_sat;
                        end
                    end
                end
                res_kind_next = KIND_END;
                res_data_next = '{
                    dropped_count: (ts_reg > frame_reg) ? CntW'(ts_reg - frame_reg) : '0,
                    pad_count:     (frame_reg > ts_reg) ? CntW'(frame_reg - ts_reg) : '0,
                    frame_length:  frame_reg,
                    sample_value:  '0,
                    sample_index:  '0};
            end else begin
                fall_next = in_d.edge_tick;
            end
        end

        if (cmd.finish) begin
            frame_next    = q_sat;
            res_kind_next = KIND_CAL;
            res_data_next = '{dropped_count: '0, pad_count: '0, frame_length: q_sat,
                              sample_value: '0, sample_index: '0};
        end

        if (cmd.move) begin
            out_kind_next = res_kind_reg;
            out_data_next = res_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg  <= MARK_GAP_RST;
            long_reg  <= LONG_GAP_RST;
            short_reg <= SHORT_GAP_RST;
            warm_reg  <= WARMUP_RST;
            meas_reg  <= MEASURE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MARK_GAP_MIN:  mark_reg  <= cfg_data;
                REG_LONG_GAP_MIN:  long_reg  <= cfg_data;
                REG_SHORT_GAP_MAX: short_reg <= cfg_data;
                REG_WARMUP_TURNS:  warm_reg  <= cfg_data[TurnCfgW-1:0];
                REG_MEASURE_TURNS: meas_reg  <= cfg_data[TurnCfgW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fall_reg  <= '0;
            prev_reg  <= '0;
            armed_reg <= 1'b0;
            cal_reg   <= 1'b0;
            tc_reg    <= '0;
            sum_reg   <= '0;
            frame_reg <= '0;
            ts_reg    <= '0;
        end else begin
            fall_reg  <= fall_next;
            prev_reg  <= prev_next;
            armed_reg <= armed_next;
            cal_reg   <= cal_next;
            tc_reg    <= tc_next;
            sum_reg   <= sum_next;
            frame_reg <= frame_next;
            ts_reg    <= ts_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_kind_reg <= res_kind_next;
        res_data_reg <= res_data_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign m_tuser = out_kind_reg;
    assign m_tdata = out_data_reg;

endmodule

// ===== design/rsf_ctrl.sv =====
module rsf_ctrl
    import rsf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic state_reg, state_next;
    logic res_valid_reg, res_valid_next;
    logic out_valid_reg, out_valid_next;
    logic load;

    assign s_tready   = (state_reg == ST_IDLE) && !res_valid_reg;
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.finish = (state_reg == ST_DIV) && sts.div_done;
    assign cmd.move   = res_valid_reg && (!out_valid_reg || m_tready);
    assign load       = (cmd.accept && sts.res_now) || cmd.finish;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && sts.need_div) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // result stage only loads when empty, so load and move never overlap
        res_valid_next = load || (res_valid_reg && !cmd.move);
        if (cmd.move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== design/rsf_checker.sv =====
`include "revolution_scan_framer_macros.svh"

module rsf_checker
    import rsf_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [KindW-1:0] m_tuser,
    input logic [63:0]      m_tdata
);

    out_data_t od;
    assign od = out_data_t'(m_tdata);

    `RSF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `RSF_ASSERT(a_ctl_no_sample, m_tvalid && m_tuser != KIND_SAMPLE |-> od.sample_index == '0 && od.sample_value == '0, "control beat carries sample fields")
    `RSF_ASSERT(a_pad_or_drop, m_tvalid && m_tuser == KIND_END |-> od.pad_count == '0 || od.dropped_count == '0, "frame end reports both pad and drop")
    `RSF_ASSERT(a_index_in_frame, m_tvalid && m_tuser == KIND_SAMPLE |-> od.sample_index < od.frame_length, "sample index beyond frame length")
    `RSF_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind revolution_scan_framer rsf_checker u_rsf_checker (.*);
